// ===== rtl/vlp_pkg.sv =====
package vlp_pkg;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int DIV_W    = 15;
    localparam int WEIGHT_W = 16;
    localparam int COUNT_W  = 4;
    localparam int CH_W     = 3;

    localparam int MAX_CHANNELS = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_MUL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DIV  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_WEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CH_COUNT  = 3'd4;

    // Serial datapath: radix-4 digits
    localparam int DIGIT_W   = 2;
    localparam int OPND_W    = SAMPLE_W + 1;
    localparam int ACC_HI_W  = 20;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int MAC_STEPS = WEIGHT_W / DIGIT_W;
    localparam int MAC_CNT_W = $clog2(MAC_STEPS);
    localparam int DIV_STEPS = PROD_W / DIGIT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Operands of the shared multiply-accumulate: a*ma + b*mb
    // a and b hold two's complement values.
    typedef struct packed {
        logic [OPND_W-1:0]   a;
        logic [WEIGHT_W-1:0] ma;
        logic [OPND_W-1:0]   b;
        logic [WEIGHT_W-1:0] mb;
    } t_mac_op;

endpackage

// ===== rtl/vlp_in_if.sv =====
interface vlp_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [vlp_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

// ===== rtl/vlp_out_if.sv =====
interface vlp_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [vlp_pkg::SAMPLE_W-1:0] sample_out;
    logic                                gain_wrapped;
    logic [vlp_pkg::CH_W-1:0]            channel_index;

    modport source (output valid, output sample_out, output gain_wrapped,
                    output channel_index, input ready);
    modport sink   (input valid, input sample_out, input gain_wrapped,
                    input channel_index, output ready);
endinterface

// ===== rtl/vlp_mac.sv =====
module vlp_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  vlp_pkg::t_mac_op                    i_op,
    output logic                                o_done,
    output logic signed [vlp_pkg::ACC_HI_W-1:0] o_hi,
    output logic [vlp_pkg::WEIGHT_W-1:0]        o_lo
);

    // Digit product v*d, d one radix digit
    function automatic logic signed [vlp_pkg::ACC_HI_W-1:0] dmul(
        input logic signed [vlp_pkg::OPND_W-1:0] v,
        input logic [vlp_pkg::DIGIT_W-1:0]       d
    );
        logic signed [vlp_pkg::ACC_HI_W-1:0] ext;
        logic signed [vlp_pkg::ACC_HI_W-1:0] acc;
        ext = vlp_pkg::ACC_HI_W'(v);
        acc = '0;
        for (int j = 0; j < vlp_pkg::DIGIT_W; j++) begin
            if (d[j]) begin
                acc = acc + (ext <<< j);
            end
        end
        return acc;
    endfunction

    logic                                r_busy;
    logic                                r_done;
    logic [vlp_pkg::MAC_CNT_W-1:0]       r_cnt;
    vlp_pkg::t_mac_op                    r_op;
    logic signed [vlp_pkg::ACC_HI_W-1:0] r_p;
    logic [vlp_pkg::WEIGHT_W-1:0]        r_lo;

    logic signed [vlp_pkg::ACC_HI_W-1:0] sum;
    logic signed [vlp_pkg::ACC_HI_W-1:0] n_p;
    logic [vlp_pkg::WEIGHT_W-1:0]        n_lo;

    // Shift-right accumulate: low digit of the sum drops into r_lo each step
    always_comb begin
        sum  = r_p + dmul($signed(r_op.a), r_op.ma[vlp_pkg::DIGIT_W-1:0])
                   + dmul($signed(r_op.b), r_op.mb[vlp_pkg::DIGIT_W-1:0]);
        n_p  = sum >>> vlp_pkg::DIGIT_W;
        n_lo = {sum[vlp_pkg::DIGIT_W-1:0], r_lo[vlp_pkg::WEIGHT_W-1:vlp_pkg::DIGIT_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == vlp_pkg::MAC_CNT_W'(vlp_pkg::MAC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op <= i_op;
            r_p  <= '0;
            r_lo <= '0;
        end else if (r_busy) begin
            r_op.ma <= r_op.ma >> vlp_pkg::DIGIT_W;
            r_op.mb <= r_op.mb >> vlp_pkg::DIGIT_W;
            r_p     <= n_p;
            r_lo    <= n_lo;
        end
    end

    assign o_done = r_done;
    assign o_hi   = r_p;
    assign o_lo   = r_lo;

endmodule

// ===== rtl/vlp_div.sv =====
module vlp_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [vlp_pkg::PROD_W-1:0]   i_dividend,
    input  logic [vlp_pkg::DIV_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [vlp_pkg::PROD_W-1:0]   o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [vlp_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [vlp_pkg::DIV_W-1:0]     r_rem;
    logic [vlp_pkg::DIV_W-1:0]     r_div;
    logic [vlp_pkg::PROD_W-1:0]    r_quo;

    logic [vlp_pkg::DIV_W:0]       trial;
    logic [vlp_pkg::DIV_W-1:0]     n_rem;
    logic [vlp_pkg::PROD_W-1:0]    n_quo;

    // Restoring division, one radix digit per cycle. Dividend bits leave
    // the top of r_quo while quotient bits enter at the bottom.
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        trial = '0;
        for (int k = 0; k < vlp_pkg::DIGIT_W; k++) begin
            trial = {n_rem, n_quo[vlp_pkg::PROD_W-1]};
            n_quo = {n_quo[vlp_pkg::PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                trial    = trial - {1'b0, r_div};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[vlp_pkg::DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == vlp_pkg::DIV_CNT_W'(vlp_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            // zero divisor acts as one
            r_div <= (i_divisor == '0) ? vlp_pkg::DIV_W'(1) : i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/volume_and_one_pole_lowpass.sv =====
// Volume scaling and one-pole lowpass for interleaved 16-bit audio.
//
// Channels: i_in carries one signed sample per beat; o_out returns one beat
// per input beat with the result sample, a gain wrap flag and the channel
// the sample belonged to. Both use valid/ready; a beat moves when both are
// high. Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user must write them only while the block is idle, as the block itself
// does not enforce it.
// Timing: one item at a time. A radix-4 multiply-accumulate unit and a
// radix-4 restoring divider do the work in turn: gain multiply, gain
// divide, then lowpass multiply-accumulate. The next input can be taken in
// the cycle after the result is loaded.
//
// The finished result sits in an output register; when the receiver stalls,
// the next sample is still taken and worked up, and only waits at the end
// if the output register is still full.
//
// Reset (synchronous, active low) restores register defaults (gain 1/1,
// lowpass off, two channels), clears the channel counter and all history.
module volume_and_one_pole_lowpass (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    vlp_in_if.sink                            i_in,
    vlp_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [vlp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [vlp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FILT,
        S_OUT
    } t_state;

    t_state r_state;

    // Configuration
    logic signed [vlp_pkg::SAMPLE_W-1:0] r_gain_mul;
    logic [vlp_pkg::DIV_W-1:0]           r_gain_div;
    logic [vlp_pkg::WEIGHT_W-1:0]        r_in_w;
    logic [vlp_pkg::WEIGHT_W-1:0]        r_fb_w;
    logic [vlp_pkg::COUNT_W-1:0]         r_ch_cnt;

    // Per-item state
    logic                                r_neg;       // sign of the gain product
    logic                                r_filt_en;
    logic [vlp_pkg::CH_W-1:0]            r_ch;
    logic [vlp_pkg::SAMPLE_W-1:0]        r_s;
    logic                                r_wrap;

    logic [vlp_pkg::CH_W-1:0]            r_counter;
    logic [vlp_pkg::SAMPLE_W-1:0]        r_hist [vlp_pkg::MAX_CHANNELS];

    // Output register
    logic                                r_out_valid;
    logic [vlp_pkg::SAMPLE_W-1:0]        r_out_sample;
    logic                                r_out_wrap;
    logic [vlp_pkg::CH_W-1:0]            r_out_ch;

    logic                                in_fire;
    logic                                out_free;
    logic [vlp_pkg::SAMPLE_W-1:0]        x_mag;
    logic [vlp_pkg::SAMPLE_W-1:0]        mul_mag;
    logic                                count_ok;
    logic [vlp_pkg::CH_W-1:0]            ch_cur;
    logic [vlp_pkg::CH_W-1:0]            ch_next;

    logic                                mac_start;
    logic                                mac_done;
    vlp_pkg::t_mac_op                    mac_op;
    vlp_pkg::t_mac_op                    gain_op;
    vlp_pkg::t_mac_op                    filt_op;
    logic signed [vlp_pkg::ACC_HI_W-1:0] mac_hi;
    logic [vlp_pkg::WEIGHT_W-1:0]        mac_lo;

    logic                                div_start;
    logic                                div_done;
    logic [vlp_pkg::PROD_W-1:0]          quo;

    logic [vlp_pkg::SAMPLE_W-1:0]        s16;
    logic                                wrap;
    logic [vlp_pkg::SAMPLE_W-1:0]        y16;
    logic [vlp_pkg::SAMPLE_W-1:0]        hist_rd;

    assign in_fire    = i_in.valid && (r_state == S_IDLE);
    assign i_in.ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || o_out.ready;

    // Gain multiply in sign-magnitude; -32768 maps to 32768
    assign x_mag   = i_in.sample_in[vlp_pkg::SAMPLE_W-1]
                     ? (~i_in.sample_in + 1'b1) : i_in.sample_in;
    assign mul_mag = r_gain_mul[vlp_pkg::SAMPLE_W-1]
                     ? (~r_gain_mul + 1'b1) : r_gain_mul;

    // Channel sequencing; a counter past a lowered count restarts at 0
    assign count_ok = (r_ch_cnt != '0) &&
                      (r_ch_cnt <= vlp_pkg::COUNT_W'(vlp_pkg::MAX_CHANNELS));
    assign ch_cur   = ({1'b0, r_counter} >= r_ch_cnt) ? '0 : r_counter;
    assign ch_next  = ((vlp_pkg::COUNT_W'(ch_cur) + 1'b1) >= r_ch_cnt)
                      ? '0 : (ch_cur + 1'b1);

    // Quotient magnitude back to a signed 16-bit value with wrap detect
    assign wrap = (|quo[vlp_pkg::PROD_W-1:vlp_pkg::SAMPLE_W]) ||
                  (quo[vlp_pkg::SAMPLE_W-1] &&
                   (r_neg ? (|quo[vlp_pkg::SAMPLE_W-2:0]) : 1'b1));
    assign s16  = r_neg ? (~quo[vlp_pkg::SAMPLE_W-1:0] + 1'b1)
                        : quo[vlp_pkg::SAMPLE_W-1:0];

    assign hist_rd = r_hist[r_ch];

    // Lowpass: acc/65536 toward zero = floor, plus one when negative and inexact
    assign y16 = mac_hi[vlp_pkg::SAMPLE_W-1:0]
                 + vlp_pkg::SAMPLE_W'(mac_hi[vlp_pkg::ACC_HI_W-1] && (|mac_lo));

    always_comb begin
        gain_op.a  = {1'b0, x_mag};
        gain_op.ma = mul_mag;
        gain_op.b  = '0;
        gain_op.mb = '0;
        filt_op.a  = {s16[vlp_pkg::SAMPLE_W-1], s16};
        filt_op.ma = r_in_w;
        filt_op.b  = {hist_rd[vlp_pkg::SAMPLE_W-1], hist_rd};
        filt_op.mb = r_fb_w;
        mac_op     = (r_state == S_IDLE) ? gain_op : filt_op;
    end

    assign mac_start = in_fire || ((r_state == S_DIV) && div_done && r_filt_en);
    assign div_start = (r_state == S_MUL) && mac_done;

    vlp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mac_start),
        .i_op    (mac_op),
        .o_done  (mac_done),
        .o_hi    (mac_hi),
        .o_lo    (mac_lo)
    );

    vlp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({mac_hi[vlp_pkg::SAMPLE_W-1:0], mac_lo}),
        .i_divisor  (r_gain_div),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain_mul  <= vlp_pkg::SAMPLE_W'(1);
            r_gain_div  <= vlp_pkg::DIV_W'(1);
            r_in_w      <= '0;
            r_fb_w      <= '0;
            r_ch_cnt    <= vlp_pkg::COUNT_W'(2);
            r_counter   <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < vlp_pkg::MAX_CHANNELS; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vlp_pkg::CFG_GAIN_MUL:  r_gain_mul <= i_cfg_data;
                    vlp_pkg::CFG_GAIN_DIV:  r_gain_div <= i_cfg_data[vlp_pkg::DIV_W-1:0];
                    vlp_pkg::CFG_IN_WEIGHT: r_in_w     <= i_cfg_data;
                    vlp_pkg::CFG_FB_WEIGHT: r_fb_w     <= i_cfg_data;
                    vlp_pkg::CFG_CH_COUNT:  r_ch_cnt   <= i_cfg_data[vlp_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end

            // load wins over drain; a beat leaving as the next one loads keeps valid
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_neg     <= i_in.sample_in[vlp_pkg::SAMPLE_W-1]
                                     ^ r_gain_mul[vlp_pkg::SAMPLE_W-1];
                        r_filt_en <= count_ok && (r_in_w != '0);
                        if (count_ok) begin
                            r_ch      <= ch_cur;
                            r_counter <= ch_next;
                        end else begin
                            r_ch      <= '0;
                            r_counter <= '0;
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mac_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_s     <= s16;
                        r_wrap  <= wrap;
                        r_state <= r_filt_en ? S_FILT : S_OUT;
                    end
                end
                S_FILT: begin
                    if (mac_done) begin
                        r_s          <= y16;
                        r_hist[r_ch] <= y16;
                        r_state      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_sample <= r_s;
                        r_out_wrap   <= r_wrap;
                        r_out_ch     <= r_ch;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.sample_out    = r_out_sample;
    assign o_out.gain_wrapped  = r_out_wrap;
    assign o_out.channel_index = r_out_ch;

    // Checks
    a_mac_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> (r_state == S_MUL || r_state == S_FILT))
        else $error("multiply-accumulate finished outside its phases");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_MUL))
        else $error("accepted beat did not start the gain multiply");

    a_ch_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_filt_en) |-> ({1'b0, r_ch} < r_ch_cnt))
        else $error("filtered channel beyond channel count");

endmodule

// ===== bench/tb_volume_and_one_pole_lowpass.sv =====
`timescale 1ns / 1ps

module tb_volume_and_one_pole_lowpass;

    // Run control
    localparam int RANDOM_ITEMS = 1000;
    localparam int LIMIT_CYCLES = 4_000_000;  // several times the slowest legal run
    localparam int TAIL_CYCLES  = 80;
    localparam longint LP_SCALE = 65536;

    typedef logic [vlp_pkg::CFG_DATA_W-1:0] t_cfg_word;

    // What the driver pulls from its feed: a sample beat, a register write
    // (only issued once the block has drained), or a drain point.
    typedef enum logic [1:0] {EV_SAMPLE, EV_CFG, EV_DRAIN} t_feed_kind;

    typedef struct {
        t_feed_kind                    kind;
        logic [vlp_pkg::CFG_IDX_W-1:0] idx;
        t_cfg_word                     data;   // register value, or the sample itself
    } t_feed;

    typedef struct packed {
        logic [vlp_pkg::SAMPLE_W-1:0] sample_out;
        logic                         gain_wrapped;
        logic [vlp_pkg::CH_W-1:0]     channel_index;
    } t_filtered;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Driven signals; all known from time zero
    logic                          drv_valid  = 1'b0;
    t_cfg_word                     drv_sample = '0;
    logic                          drv_ready  = 1'b0;
    logic                          drv_we     = 1'b0;
    logic [vlp_pkg::CFG_IDX_W-1:0] drv_idx    = '0;
    t_cfg_word                     drv_data   = '0;

    vlp_in_if  in_bus ();
    vlp_out_if out_bus ();

    assign in_bus.valid     = drv_valid;
    assign in_bus.sample_in = drv_sample;
    assign out_bus.ready    = drv_ready;

    volume_and_one_pole_lowpass i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (drv_we),
        .i_cfg_idx  (drv_idx),
        .i_cfg_data (drv_data)
    );

    // Stimulus feed and expected results
    t_feed     sample_feed [$];
    t_filtered expected_samples [$];

    int errors    = 0;
    int cycle_cnt = 0;
    int sent_cnt  = 0;   // beats put on the input bus
    int taken_cnt = 0;   // beats accepted by the block

    // Local copy of the block's registers and state
    logic signed [vlp_pkg::SAMPLE_W-1:0] gain_mul;
    logic [vlp_pkg::DIV_W-1:0]           gain_div;
    logic [vlp_pkg::WEIGHT_W-1:0]        in_weight;
    logic [vlp_pkg::WEIGHT_W-1:0]        fb_weight;
    logic [vlp_pkg::COUNT_W-1:0]         ch_count;
    logic [vlp_pkg::COUNT_W-1:0]         ch_counter;
    logic signed [vlp_pkg::SAMPLE_W-1:0] history [vlp_pkg::MAX_CHANNELS];

    // Register write, masked to each register's width
    function automatic void apply_write(input logic [vlp_pkg::CFG_IDX_W-1:0] idx,
                                        input t_cfg_word data);
        case (idx)
            vlp_pkg::CFG_GAIN_MUL:  gain_mul  = data;
            vlp_pkg::CFG_GAIN_DIV:  gain_div  = data[vlp_pkg::DIV_W-1:0];
            vlp_pkg::CFG_IN_WEIGHT: in_weight = data[vlp_pkg::WEIGHT_W-1:0];
            vlp_pkg::CFG_FB_WEIGHT: fb_weight = data[vlp_pkg::WEIGHT_W-1:0];
            vlp_pkg::CFG_CH_COUNT:  ch_count  = data[vlp_pkg::COUNT_W-1:0];
            default: ;
        endcase
    endfunction

    // Gain scaling then the per-channel lowpass; advances the channel
    // counter and history exactly as one accepted beat does.
    function automatic t_filtered scale_and_filter(
        input logic signed [vlp_pkg::SAMPLE_W-1:0] smp
    );
        longint                              div_eff;
        longint                              quo;
        longint                              acc;
        logic signed [vlp_pkg::SAMPLE_W-1:0] scaled;
        logic [vlp_pkg::COUNT_W-1:0]         lane;
        t_filtered                           res;
        // a zero divisor behaves as one
        div_eff = (gain_div == '0) ? 64'sd1 : longint'(gain_div);
        quo     = (longint'(smp) * longint'(gain_mul)) / div_eff;  // truncates toward zero
        res.gain_wrapped  = (quo < -32768) || (quo > 32767);
        scaled            = quo[vlp_pkg::SAMPLE_W-1:0];
        res.channel_index = '0;
        if (ch_count >= 1 && ch_count <= vlp_pkg::MAX_CHANNELS) begin
            // count lowered under the counter: restart at channel 0
            if (ch_counter >= ch_count) ch_counter = '0;
            lane = ch_counter;
            if (in_weight != '0) begin
                acc = longint'(scaled) * longint'(in_weight)
                    + longint'(history[lane[vlp_pkg::CH_W-1:0]]) * longint'(fb_weight);
                quo    = acc / LP_SCALE;
                scaled = quo[vlp_pkg::SAMPLE_W-1:0];   // wraps silently, no flag
                history[lane[vlp_pkg::CH_W-1:0]] = scaled;
            end
            ch_counter = (lane + 1 >= ch_count) ? '0 : lane + 1'b1;
            res.channel_index = lane[vlp_pkg::CH_W-1:0];
        end else begin
            // bad count: bypass lowpass, history untouched, channel 0
            ch_counter = '0;
        end
        res.sample_out = scaled;
        return res;
    endfunction

    task automatic report_field(input string field, input longint want, input longint seen);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, seen);
        errors++;
    endtask

    // Rising edge: register writes and input beats feed the local copy,
    // output beats are checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_filtered want;
        cycle_cnt++;
        if (!i_rst_n) begin
            gain_mul   = 16'sd1;
            gain_div   = 15'd1;
            in_weight  = '0;
            fb_weight  = '0;
            ch_count   = 4'd2;
            ch_counter = '0;
            foreach (history[i]) history[i] = '0;
        end else begin
            if (drv_we) apply_write(drv_idx, drv_data);
            if (in_bus.valid && in_bus.ready) begin
                expected_samples.push_back(scale_and_filter(in_bus.sample_in));
                taken_cnt++;
            end
            if (out_bus.valid && out_bus.ready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: output beat with nothing expected, sample_out %0d",
                             $time, out_bus.sample_out);
                    errors++;
                end else begin
                    want = expected_samples.pop_front();
                    if (out_bus.sample_out !== want.sample_out)
                        report_field("sample_out", longint'($signed(want.sample_out)),
                                     longint'(out_bus.sample_out));
                    if (out_bus.gain_wrapped !== want.gain_wrapped)
                        report_field("gain_wrapped", longint'(want.gain_wrapped),
                                     longint'(out_bus.gain_wrapped));
                    if (out_bus.channel_index !== want.channel_index)
                        report_field("channel_index", longint'(want.channel_index),
                                     longint'(out_bus.channel_index));
                end
            end
        end
    end

    // Sender: bursts of random length with random gaps. Register writes and
    // drain points hold the feed until every expected beat has come back.
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        logic  nxt_valid;
        logic  nxt_we;
        t_feed head;
        nxt_valid = drv_valid;
        nxt_we    = 1'b0;
        if (i_rst_n) begin
            if (drv_valid && taken_cnt == sent_cnt) nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (sample_feed.size() > 0) begin
                    head = sample_feed[0];
                    case (head.kind)
                        EV_SAMPLE: begin
                            nxt_valid  = 1'b1;
                            drv_sample <= head.data;
                            sent_cnt++;
                            void'(sample_feed.pop_front());
                            burst_left--;
                            if (burst_left == 0) begin
                                burst_left = $urandom_range(1, 40);
                                gap_left   = ($urandom_range(0, 2) == 0) ? 0
                                                                        : $urandom_range(1, 80);
                            end
                        end
                        EV_CFG: begin
                            if (expected_samples.size() == 0) begin
                                nxt_we   = 1'b1;
                                drv_idx  <= head.idx;
                                drv_data <= head.data;
                                void'(sample_feed.pop_front());
                            end
                        end
                        default: begin
                            if (expected_samples.size() == 0) void'(sample_feed.pop_front());
                        end
                    endcase
                end
            end
        end
        drv_valid <= nxt_valid;
        drv_we    <= nxt_we;
    end

    // Receiver: alternating ready runs; mostly short stalls, some long ones,
    // and now and then a long stretch with no stall at all.
    int stall_run = 0;

    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            if (drv_ready)
                stall_run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 100)
                                                       : $urandom_range(1, 4);
            else
                stall_run = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 600)
                                                       : $urandom_range(1, 40);
            drv_ready <= !drv_ready;
        end else begin
            stall_run--;
        end
    end

    task automatic push_sample(input t_cfg_word smp);
        sample_feed.push_back('{EV_SAMPLE, '0, smp});
    endtask

    task automatic push_write(input logic [vlp_pkg::CFG_IDX_W-1:0] idx, input t_cfg_word data);
        sample_feed.push_back('{EV_CFG, idx, data});
    endtask

    initial begin
        int        n_random;
        int        blk;
        bit        timed_out;
        t_cfg_word v;
        t_cfg_word last_iw;

        // ---- directed part ----
        // reset setting: unity gain, lowpass off, two channels
        push_sample(16'h0000);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'hFFFF);
        push_sample(16'h0001);
        push_sample(16'h5555);
        push_sample(16'hAAAA);
        // most negative gain: -32768 * -32768 wraps, 1 does not
        push_write(vlp_pkg::CFG_GAIN_MUL, 16'h8000);
        push_sample(16'h8000);
        push_sample(16'h0001);
        push_sample(16'hFFFF);
        // equal multiplier and divisor leave the sample alone
        push_write(vlp_pkg::CFG_GAIN_MUL, 16'h7FFF);
        push_write(vlp_pkg::CFG_GAIN_DIV, 16'h7FFF);
        push_sample(16'h8000);
        // zero divisor acts as one; 3 * 20000 wraps
        push_write(vlp_pkg::CFG_GAIN_MUL, 16'h0003);
        push_write(vlp_pkg::CFG_GAIN_DIV, 16'h0000);
        push_sample(16'h4E20);
        // full-scale lowpass on three channels, sum overflows 16 bits;
        // divisor top bit lies outside the register
        push_write(vlp_pkg::CFG_GAIN_MUL, 16'h0001);
        push_write(vlp_pkg::CFG_GAIN_DIV, 16'h8001);
        push_write(vlp_pkg::CFG_IN_WEIGHT, 16'hFFFF);
        push_write(vlp_pkg::CFG_FB_WEIGHT, 16'hFFFF);
        push_write(vlp_pkg::CFG_CH_COUNT, 16'h0003);
        repeat (5) push_sample(16'h7FFF);
        // counter now sits at 2: lowering the count restarts it
        push_write(vlp_pkg::CFG_CH_COUNT, 16'h0002);
        push_sample(16'h7FFF);
        // out-of-range counts bypass the lowpass
        push_write(vlp_pkg::CFG_CH_COUNT, 16'h0000);
        push_sample(16'h1234);
        push_write(vlp_pkg::CFG_CH_COUNT, 16'h0009);
        push_sample(16'h8000);
        push_write(vlp_pkg::CFG_CH_COUNT, 16'h000F);
        push_sample(16'h7FFF);
        // eight channels, tiny weight: negative result truncates toward zero
        push_write(vlp_pkg::CFG_CH_COUNT, 16'h0008);
        push_write(vlp_pkg::CFG_IN_WEIGHT, 16'h0001);
        push_write(vlp_pkg::CFG_FB_WEIGHT, 16'h0000);
        push_sample(16'hFFFF);
        push_sample(16'h7FFF);
        last_iw = 16'h0001;

        // ---- random part: phases of fresh settings, each a block of samples ----
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 5))
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    2:       v = 16'h0001;
                    3:       v = 16'hFFFF;
                    default: v = t_cfg_word'($urandom);
                endcase
                push_write(vlp_pkg::CFG_GAIN_MUL, v);
            end
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 5))
                    0:       v = 16'h0000;
                    1:       v = 16'h0001;
                    2:       v = 16'h7FFF;
                    3:       v = t_cfg_word'($urandom_range(2, 16));
                    default: v = t_cfg_word'($urandom);   // bit 15 ignored
                endcase
                push_write(vlp_pkg::CFG_GAIN_DIV, v);
            end
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 5))
                    0:       v = 16'h0000;   // lowpass off
                    1:       v = 16'hFFFF;
                    2:       v = 16'h0001;
                    default: v = t_cfg_word'($urandom);
                endcase
                push_write(vlp_pkg::CFG_IN_WEIGHT, v);
                last_iw = v;
            end
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 4))
                    0:       v = 16'h0000;
                    1:       v = 16'hFFFF;
                    2:       v = t_cfg_word'(65536 - int'(last_iw));  // unity DC gain
                    default: v = t_cfg_word'($urandom);
                endcase
                push_write(vlp_pkg::CFG_FB_WEIGHT, v);
            end
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 7))
                    0:       v = 16'h0000;
                    1:       v = t_cfg_word'($urandom_range(9, 15));
                    2:       v = 16'h0008;
                    3:       v = 16'h0001;
                    default: v = t_cfg_word'($urandom_range(1, 8));
                endcase
                push_write(vlp_pkg::CFG_CH_COUNT, v);
            end
            blk = $urandom_range(10, 60);
            for (int k = 0; k < blk; k++) begin
                case ($urandom_range(0, 7))
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    2:       v = t_cfg_word'($urandom_range(0, 64) - 32);
                    default: v = t_cfg_word'($urandom);
                endcase
                push_sample(v);
                // sender holds off mid-block until all results are back
                if (k == blk / 2 && $urandom_range(0, 3) == 0)
                    sample_feed.push_back('{EV_DRAIN, '0, '0});
            end
            n_random += blk;
        end

        // ---- reset, then let the driver run ----
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (cycle_cnt < LIMIT_CYCLES &&
               (sample_feed.size() != 0 || drv_valid || expected_samples.size() != 0))
            @(posedge i_clk);
        timed_out = (cycle_cnt >= LIMIT_CYCLES);
        if (!timed_out) repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_samples.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, expected_samples.size());
            errors++;
        end
        if (!timed_out && errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
